[rtl/lz77_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the LZ77 stream decoder.
// No dependencies.
package lz77_pkg;

    localparam int WINDOW_DEF   = 65536;
    localparam int POS_BITS_DEF = 24;
    localparam int CNT_W        = 24;   // image/compressed size and byte counters

    localparam logic [7:0] LIT_TAG  = 8'h80;

    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_LITLEN  = 3'd1,
        PH_LITDATA = 3'd2,
        PH_DIST    = 3'd3,
        PH_LEN     = 3'd4,
        PH_COPY    = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_LIT  = 3'd1,
        ST_BAD_DIST = 3'd2,
        ST_BAD_LEN  = 3'd3,
        ST_DROPPED  = 3'd4,
        ST_IGNORED  = 3'd5
    } status_t;

    typedef enum logic {
        REG_IMAGE_SIZE      = 1'b0,
        REG_COMPRESSED_SIZE = 1'b1
    } reg_idx_t;

    // 7-bit varint group placed at its position; groups past the fifth drop out
    function automatic logic [31:0] vgroup(input logic [2:0] idx, input logic [6:0] g);
        logic [31:0] gx;
        logic [31:0] r;
        gx = {25'd0, g};
        unique case (idx)
            3'd0:    r = gx;
            3'd1:    r = gx << 7;
            3'd2:    r = gx << 14;
            3'd3:    r = gx << 21;
            3'd4:    r = gx << 28;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/lz77_stream_decoder.sv]
`timescale 1ns / 1ps
// LZ77 stream decoder: parser, history window memory, output register.
// Depends on lz77_pkg.
//
// Pipeline: an accepted input transaction passes the history read stage, then
//   the output register, which drives m_.
// Throughput: one transaction per cycle, sustained while m_ready stays high;
//   the history memory read is registered and pipelined behind the parser.
// Reset: aresetn synchronous, active low; clears parser state, counters and
//   size registers. History memory is not cleared (no clearing pass needed).
module lz77_stream_decoder #(
    parameter int WINDOW   = lz77_pkg::WINDOW_DEF,
    parameter int POS_BITS = lz77_pkg::POS_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_op,
    input  logic [7:0]                 s_in_byte,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_has_byte,
    output logic [7:0]                 m_out_byte,
    output logic                       m_last,
    output logic                       m_copy_pending,
    output logic [2:0]                 m_status,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [lz77_pkg::CNT_W-1:0] cfg_data
);

    localparam int CW = lz77_pkg::CNT_W;
    localparam int AW = $clog2(WINDOW);
    // width for the wrapped source address subtraction
    localparam int EW = ((POS_BITS > AW) ? POS_BITS : AW) + 2;

    // ---------------------------------------------------------------
    // Configuration registers, always ready
    // ---------------------------------------------------------------
    logic [CW-1:0] image_size_reg;
    logic [CW-1:0] comp_size_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_size_reg <= '0;
            comp_size_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (lz77_pkg::reg_idx_t'(cfg_index))
                lz77_pkg::REG_IMAGE_SIZE:      image_size_reg <= cfg_data;
                lz77_pkg::REG_COMPRESSED_SIZE: comp_size_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Parser state
    // ---------------------------------------------------------------
    lz77_pkg::phase_t    phase_reg, phase_next;
    logic [2:0]          idx_reg, idx_next;
    logic [31:0]         acc_reg, acc_next;
    logic [POS_BITS-1:0] dist_reg, dist_next;
    logic [CW-1:0]       remain_reg, remain_next;
    logic [CW-1:0]       out_pos_reg, out_pos_next;
    logic [CW-1:0]       in_pos_reg, in_pos_next;
    logic                halted_reg, halted_next;
    logic [AW-1:0]       wptr_reg, wptr_next;   // out_pos modulo WINDOW

    // Stage 1: waits on the history read, writes the emitted byte back.
    logic                s1_valid_reg;
    logic                s1_wr_reg;       // item emits a byte
    logic                s1_copy_reg;     // byte comes from history
    logic                s1_fwd_reg;      // read hit the entry written alongside it
    logic [7:0]          s1_lit_reg;
    logic [AW-1:0]       s1_addr_reg;
    logic                s1_last_reg;
    logic                s1_pend_reg;
    logic [2:0]          s1_status_reg;
    logic [7:0]          fwd_data_reg;
    logic [7:0]          rdata_reg;
    logic [7:0]          s1_byte;
    logic                s1_adv;

    // Output register
    logic                m_valid_reg;
    logic                m_has_reg;
    logic [7:0]          m_byte_reg;
    logic                m_last_reg;
    logic                m_pend_reg;
    logic [2:0]          m_status_reg;

    logic                accept;

    // Combinational results of the parser for the item being accepted
    lz77_pkg::status_t   st;
    logic                emit;
    logic                from_hist;
    logic [7:0]          lit_b;
    logic                last_b;
    logic                pend_b;
    logic [AW-1:0]       rd_addr;

    // varint feed helpers
    logic                tag_ph;
    logic [31:0]         acc_base;
    logic [2:0]          idx_base;
    logic [31:0]         fed_acc;
    logic [2:0]          fed_idx;
    logic [POS_BITS-1:0] dist_sat;
    logic [31:0]         lit_acc;
    logic                dist_bad;
    logic                len_bad;
    logic                done;
    logic [EW-1:0]       src_diff;
    logic [EW-1:0]       src_wrap;

    // Stage 1 moves on when the output register is free or being drained.
    assign s1_adv  = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || s1_adv;
    assign accept  = s_valid && s_ready;

    assign done = (out_pos_reg >= image_size_reg);

    // Varint accumulation; the tag byte is the first distance group.
    assign tag_ph   = (phase_reg == lz77_pkg::PH_TAG);
    assign acc_base = tag_ph ? 32'd0 : acc_reg;
    assign idx_base = tag_ph ? 3'd0 : idx_reg;
    assign fed_acc  = acc_base | lz77_pkg::vgroup(idx_base, s_in_byte[6:0]);
    assign fed_idx  = (idx_base < 3'd7) ? idx_base + 3'd1 : idx_base;
    assign dist_sat = (|fed_acc[31:POS_BITS]) ? {POS_BITS{1'b1}} : fed_acc[POS_BITS-1:0];

    // Little-endian literal length
    assign lit_acc = acc_reg | ({24'd0, s_in_byte} << {idx_reg[1:0], 3'b000});

    assign dist_bad = (dist_reg == '0)
                   || (32'(dist_reg) > 32'(out_pos_reg))
                   || (33'(dist_reg) > 33'(WINDOW));
    assign len_bad  = fed_acc > 32'(image_size_reg);

    // Source address = (write pointer - distance) wrapped into the window.
    // Distance is never above WINDOW while copying, so one correction does.
    assign src_diff = EW'(wptr_reg) - EW'(dist_reg);
    assign src_wrap = src_diff[EW-1] ? (src_diff + EW'(WINDOW)) : src_diff;
    assign rd_addr  = src_wrap[AW-1:0];

    always_comb begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        acc_next    = acc_reg;
        dist_next   = dist_reg;
        remain_next = remain_reg;
        out_pos_next = out_pos_reg;
        in_pos_next = in_pos_reg;
        halted_next = halted_reg;
        wptr_next   = wptr_reg;
        st          = lz77_pkg::ST_OK;
        emit        = 1'b0;
        from_hist   = 1'b0;
        lit_b       = 8'd0;

        if (s_op) begin
            // tick: drain one copy byte
            if (halted_reg || done) begin
                st = lz77_pkg::ST_IGNORED;
            end else if (phase_reg == lz77_pkg::PH_COPY) begin
                emit        = 1'b1;
                from_hist   = 1'b1;
                remain_next = remain_reg - CW'(1);
                if (remain_reg == CW'(1)) begin
                    phase_next = lz77_pkg::PH_TAG;
                end
            end
        end else if (halted_reg || done || (in_pos_reg >= comp_size_reg)) begin
            st = lz77_pkg::ST_IGNORED;
        end else if (phase_reg == lz77_pkg::PH_COPY) begin
            st = lz77_pkg::ST_DROPPED;
        end else begin
            in_pos_next = in_pos_reg + CW'(1);
            unique case (phase_reg)
                lz77_pkg::PH_TAG: begin
                    if (s_in_byte == lz77_pkg::LIT_TAG) begin
                        acc_next   = 32'd0;
                        idx_next   = 3'd0;
                        phase_next = lz77_pkg::PH_LITLEN;
                    end else if (s_in_byte[7]) begin
                        dist_next  = dist_sat;
                        acc_next   = 32'd0;
                        idx_next   = 3'd0;
                        phase_next = lz77_pkg::PH_LEN;
                    end else begin
                        acc_next   = fed_acc;
                        idx_next   = fed_idx;
                        phase_next = lz77_pkg::PH_DIST;
                    end
                end
                lz77_pkg::PH_LITLEN: begin
                    acc_next = lit_acc;
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd3) begin
                        if (lit_acc > 32'(image_size_reg)) begin
                            st = lz77_pkg::ST_BAD_LIT;
                        end else begin
                            remain_next = lit_acc[CW-1:0];
                            phase_next  = (lit_acc == 32'd0) ? lz77_pkg::PH_TAG
                                                             : lz77_pkg::PH_LITDATA;
                        end
                    end
                end
                lz77_pkg::PH_LITDATA: begin
                    emit        = 1'b1;
                    lit_b       = s_in_byte;
                    remain_next = remain_reg - CW'(1);
                    if (remain_reg == CW'(1)) begin
                        phase_next = lz77_pkg::PH_TAG;
                    end
                end
                lz77_pkg::PH_DIST: begin
                    acc_next = fed_acc;
                    idx_next = fed_idx;
                    if (s_in_byte[7]) begin
                        dist_next  = dist_sat;
                        acc_next   = 32'd0;
                        idx_next   = 3'd0;
                        phase_next = lz77_pkg::PH_LEN;
                    end
                end
                lz77_pkg::PH_LEN: begin
                    acc_next = fed_acc;
                    idx_next = fed_idx;
                    if (s_in_byte[7]) begin
                        if (dist_bad) begin
                            st = lz77_pkg::ST_BAD_DIST;
                        end else if (len_bad) begin
                            st = lz77_pkg::ST_BAD_LEN;
                        end else begin
                            remain_next = fed_acc[CW-1:0];
                            phase_next  = (fed_acc == 32'd0) ? lz77_pkg::PH_TAG
                                                             : lz77_pkg::PH_COPY;
                        end
                    end
                end
                default: ;
            endcase
            if (st != lz77_pkg::ST_OK) begin
                halted_next = 1'b1;
                phase_next  = lz77_pkg::PH_TAG;
            end
        end

        if (emit) begin
            out_pos_next = out_pos_reg + CW'(1);
            wptr_next    = (wptr_reg == AW'(WINDOW - 1)) ? '0 : wptr_reg + AW'(1);
        end

        last_b = emit && (out_pos_next >= image_size_reg);
        pend_b = (phase_next == lz77_pkg::PH_COPY) && !halted_next
              && (out_pos_next < image_size_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= lz77_pkg::PH_TAG;
            idx_reg     <= '0;
            acc_reg     <= '0;
            dist_reg    <= '0;
            remain_reg  <= '0;
            out_pos_reg <= '0;
            in_pos_reg  <= '0;
            halted_reg  <= 1'b0;
            wptr_reg    <= '0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            acc_reg     <= acc_next;
            dist_reg    <= dist_next;
            remain_reg  <= remain_next;
            out_pos_reg <= out_pos_next;
            in_pos_reg  <= in_pos_next;
            halted_reg  <= halted_next;
            wptr_reg    <= wptr_next;
        end
    end

    // ---------------------------------------------------------------
    // History window. Stage 1 writes its byte in the cycle it leaves, which
    // can be the cycle the next transaction reads; a hit on that entry takes the
    // byte from the forward register instead of the stale read data.
    // ---------------------------------------------------------------
    logic [7:0] hist_mem [WINDOW];

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s1_wr_reg && s1_adv) begin
            hist_mem[s1_addr_reg] <= s1_byte;
        end
        if (accept && from_hist) begin
            rdata_reg <= hist_mem[rd_addr];
        end
    end

    assign s1_byte = s1_copy_reg ? (s1_fwd_reg ? fwd_data_reg : rdata_reg) : s1_lit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_wr_reg     <= emit;
            s1_copy_reg   <= from_hist;
            s1_fwd_reg    <= s1_valid_reg && s1_wr_reg && (s1_addr_reg == rd_addr);
            fwd_data_reg  <= s1_byte;
            s1_lit_reg    <= lit_b;
            s1_addr_reg   <= wptr_reg;
            s1_last_reg   <= last_b;
            s1_pend_reg   <= pend_b;
            s1_status_reg <= st;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_valid_reg) begin
            m_has_reg    <= s1_wr_reg;
            m_byte_reg   <= s1_byte;
            m_last_reg   <= s1_last_reg;
            m_pend_reg   <= s1_pend_reg;
            m_status_reg <= s1_status_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_has_byte     = m_has_reg;
    assign m_out_byte     = m_byte_reg;
    assign m_last         = m_last_reg;
    assign m_copy_pending = m_pend_reg;
    assign m_status       = m_status_reg;

endmodule
